// ----- hw/rtl/rrf_pkg.sv -----
// Shared types, field widths and codes of the record ring FIFO.
`default_nettype none

package rrf_pkg;

  localparam int DEF_RING_DEPTH = 1024;
  localparam int DEF_MAX_RECORD = 64;

  localparam int WORD_W     = 16;
  localparam int KIND_W     = 2;
  localparam int REQ_W      = 11;
  localparam int CFG_RW_W   = 7;
  localparam int CFG_BW_W   = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RECORD_WORDS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WORDS = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] data_word;
    logic [REQ_W-1:0]  request_count;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word_out;
    logic              last_word;
    logic              is_empty;
    logic              will_be_full;
    logic              has_room;
    logic              has_data;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_QUERY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [WORD_W-1:0] data_word;
    logic [REQ_W-1:0]  request_count;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_QRY1,
    ST_QRY2,
    ST_MOD_START,
    ST_MOD_WAIT
  } state_t;

  // Targets of the remainder unit, in renormalization order.
  typedef enum logic [1:0] {
    MOP_WP,
    MOP_RP,
    MOP_WADDR,
    MOP_WNEXT
  } mod_op_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rrf_mod.sv -----
// Restoring remainder unit: one numerator bit per cycle.
`default_nettype none

module rrf_mod #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 11,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [DEN_W-1:0] rem
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   shifted;

  assign shifted = {rem_r, num_r[NUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      num_nxt  = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (shifted >= {1'b0, den}) begin
        rem_nxt = DEN_W'(shifted - {1'b0, den});
      end else begin
        rem_nxt = DEN_W'(shifted);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rrf_front.sv -----
// Front end: accepts items, sorts them into commands and queues them.
`default_nettype none

module rrf_front import rrf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  wire logic     q_pop
);

  cmd_t                slot_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t                cls_cmd;
  logic                cls_ok;
  logic                push;

  // Unused kind codes are taken and dropped.
  always_comb begin
    cls_cmd.op            = CMD_INSERT;
    cls_cmd.data_word     = in_item.data_word;
    cls_cmd.request_count = in_item.request_count;
    cls_ok                = 1'b1;
    case (in_item.kind)
      KIND_INSERT: cls_cmd.op = CMD_INSERT;
      KIND_REMOVE: cls_cmd.op = CMD_REMOVE;
      KIND_QUERY:  cls_cmd.op = CMD_QUERY;
      default:     cls_ok     = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign push     = in_valid && !in_stall && cls_ok;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrf_back.sv -----
// Back end: runs queued commands against the ring store and drives results.
`default_nettype none

module rrf_back import rrf_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int MAX_RECORD = DEF_MAX_RECORD,
  localparam int ADDR_W = $clog2(RING_DEPTH),
  localparam int SIZE_W = ADDR_W + 1,
  localparam int REC_W  = $clog2(MAX_RECORD + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_written,
  input  wire logic [REC_W-1:0]  rw,
  input  wire logic [SIZE_W-1:0] bw,
  input  wire logic              q_valid,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_item
);

  localparam int NUM_W  = ((SIZE_W > REC_W) ? SIZE_W : REC_W) + 1;
  localparam int PROD_W = REQ_W + 1 + REC_W;
  localparam int CMP_W  = (PROD_W > SIZE_W) ? PROD_W : SIZE_W;

  state_t              state_r, state_nxt;
  mod_op_t             mop_r, mop_nxt;
  logic                norm_pend_r, norm_pend_nxt;
  // *_abs_r keep the pointer as last written; wp_r/rp_r are reduced by the ring size
  logic [ADDR_W-1:0]   wp_abs_r, wp_abs_nxt, wp_r, wp_nxt;
  logic [ADDR_W-1:0]   rp_abs_r, rp_abs_nxt, rp_r, rp_nxt;
  logic [ADDR_W-1:0]   waddr_r, waddr_nxt, wnext_r, wnext_nxt;
  logic [ADDR_W-1:0]   raddr_r, raddr_nxt;
  logic [REC_W-1:0]    offset_r, offset_nxt;
  logic [REC_W-1:0]    iss_cnt_r, iss_cnt_nxt, ld_cnt_r, ld_cnt_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [SIZE_W-1:0]   room_words_r, room_words_nxt, data_words_r, data_words_nxt;
  logic [PROD_W-1:0]   need_room_r, need_room_nxt, need_data_r, need_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                can_load, idle_take, do_insert, rec_done, slow_wrap;
  logic [REC_W:0]      ofs_inc, iss_inc, ld_inc;
  logic [SIZE_W-1:0]   waddr_p1, raddr_p1;
  logic [ADDR_W-1:0]   waddr_wrap, raddr_wrap, wnext_fast;
  logic [NUM_W-1:0]    wnext_sum;
  logic                issue, load_rem, last_ld, iss_last;
  logic                ptr_eq, ptr_gt;
  logic [SIZE_W-1:0]   wp_s, rp_s;
  logic                mod_start, mod_done;
  logic [NUM_W-1:0]    mod_num;
  logic [SIZE_W-1:0]   mod_rem;
  logic [WORD_W-1:0]   ram_rdata;

  // ---------------- shared decode ----------------
  assign can_load  = !out_valid_r || !out_stall;
  assign idle_take = (state_r == ST_IDLE) && !norm_pend_r && q_valid;
  assign q_pop     = idle_take;
  assign do_insert = idle_take && (q_cmd.op == CMD_INSERT);

  assign ofs_inc   = {1'b0, offset_r} + 1'b1;
  assign rec_done  = do_insert && (ofs_inc >= {1'b0, rw});
  assign slow_wrap = NUM_W'(rw) > NUM_W'(bw);

  assign waddr_p1   = {1'b0, waddr_r} + 1'b1;
  assign waddr_wrap = (waddr_p1 == bw) ? '0 : ADDR_W'(waddr_p1);
  assign raddr_p1   = {1'b0, raddr_r} + 1'b1;
  assign raddr_wrap = (raddr_p1 == bw) ? '0 : ADDR_W'(raddr_p1);

  // wnext < bw and rw <= bw keep the sum below twice the ring size
  assign wnext_sum  = NUM_W'(wnext_r) + NUM_W'(rw);
  assign wnext_fast = (wnext_sum >= NUM_W'(bw)) ? ADDR_W'(wnext_sum - NUM_W'(bw))
                                                : ADDR_W'(wnext_sum);

  assign iss_inc  = {1'b0, iss_cnt_r} + 1'b1;
  assign ld_inc   = {1'b0, ld_cnt_r} + 1'b1;
  assign issue    = (state_r == ST_REM) && (iss_cnt_r != rw) && (!rd_pend_r || can_load);
  assign load_rem = (state_r == ST_REM) && rd_pend_r && can_load;
  assign last_ld  = (ld_inc == {1'b0, rw});
  assign iss_last = (iss_inc == {1'b0, rw});

  assign ptr_eq = (wp_r == rp_r);
  assign ptr_gt = (wp_r > rp_r);
  assign wp_s   = SIZE_W'(wp_r);
  assign rp_s   = SIZE_W'(rp_r);

  assign mod_start = (state_r == ST_MOD_START);

  always_comb begin
    case (mop_r)
      MOP_WP:    mod_num = NUM_W'(wp_abs_r);
      MOP_RP:    mod_num = NUM_W'(rp_abs_r);
      MOP_WADDR: mod_num = NUM_W'(wp_r) + NUM_W'(offset_r);
      MOP_WNEXT: mod_num = NUM_W'(wp_r) + NUM_W'(rw);
      default:   mod_num = '0;
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (norm_pend_r) begin
          state_nxt = ST_MOD_START;
        end else if (q_valid) begin
          case (q_cmd.op)
            CMD_INSERT: state_nxt = (rec_done && slow_wrap) ? ST_MOD_START : ST_IDLE;
            CMD_REMOVE: state_nxt = ST_REM;
            CMD_QUERY:  state_nxt = ST_QRY1;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REM: begin
        if (load_rem && last_ld) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRY1: state_nxt = ST_QRY2;
      ST_QRY2: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD_START: state_nxt = ST_MOD_WAIT;
      ST_MOD_WAIT: begin
        if (mod_done) begin
          state_nxt = (mop_r == MOP_WNEXT) ? ST_IDLE : ST_MOD_START;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    mop_nxt        = mop_r;
    norm_pend_nxt  = norm_pend_r;
    wp_abs_nxt     = wp_abs_r;
    wp_nxt         = wp_r;
    rp_abs_nxt     = rp_abs_r;
    rp_nxt         = rp_r;
    waddr_nxt      = waddr_r;
    wnext_nxt      = wnext_r;
    raddr_nxt      = raddr_r;
    offset_nxt     = offset_r;
    iss_cnt_nxt    = iss_cnt_r;
    ld_cnt_nxt     = ld_cnt_r;
    rd_pend_nxt    = rd_pend_r;
    req_nxt        = req_r;
    room_words_nxt = room_words_r;
    data_words_nxt = data_words_r;
    need_room_nxt  = need_room_r;
    need_data_nxt  = need_data_r;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cfg_written) begin
      norm_pend_nxt = 1'b1;
    end else if ((state_r == ST_IDLE) && norm_pend_r) begin
      norm_pend_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (norm_pend_r) begin
          mop_nxt = MOP_WP;
        end else if (idle_take) begin
          case (q_cmd.op)
            CMD_INSERT: begin
              waddr_nxt  = waddr_wrap;
              offset_nxt = REC_W'(ofs_inc);
              if (rec_done) begin
                offset_nxt = '0;
                wp_nxt     = wnext_r;
                wp_abs_nxt = wnext_r;
                waddr_nxt  = wnext_r;
                if (slow_wrap) begin
                  mop_nxt = MOP_WNEXT;
                end else begin
                  wnext_nxt = wnext_fast;
                end
              end
            end
            CMD_REMOVE: begin
              raddr_nxt   = rp_r;
              iss_cnt_nxt = '0;
              ld_cnt_nxt  = '0;
              rd_pend_nxt = 1'b0;
            end
            CMD_QUERY: req_nxt = q_cmd.request_count;
            default: ;
          endcase
        end
      end
      ST_REM: begin
        if (issue) begin
          raddr_nxt   = raddr_wrap;
          iss_cnt_nxt = REC_W'(iss_inc);
          if (iss_last) begin
            rp_nxt     = raddr_wrap;
            rp_abs_nxt = raddr_wrap;
          end
        end
        rd_pend_nxt = issue || (rd_pend_r && !load_rem);
        if (load_rem) begin
          ld_cnt_nxt                 = REC_W'(ld_inc);
          out_valid_nxt              = 1'b1;
          out_item_nxt.data_word_out = ram_rdata;
          out_item_nxt.last_word     = last_ld;
          out_item_nxt.is_empty      = 1'b0;
          out_item_nxt.will_be_full  = 1'b0;
          out_item_nxt.has_room      = 1'b0;
          out_item_nxt.has_data      = 1'b0;
        end
      end
      ST_QRY1: begin
        // floor(a / rw) > req  <=>  a >= (req + 1) * rw
        need_data_nxt = PROD_W'(req_r) * PROD_W'(rw);
        need_room_nxt = (PROD_W'(req_r) + 1'b1) * PROD_W'(rw);
        if (ptr_eq) begin
          room_words_nxt = bw;
          data_words_nxt = '0;
        end else if (ptr_gt) begin
          room_words_nxt = bw - wp_s + rp_s;
          data_words_nxt = wp_s - rp_s;
        end else begin
          room_words_nxt = rp_s - wp_s;
          data_words_nxt = bw - rp_s + wp_s;
        end
      end
      ST_QRY2: begin
        if (can_load) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.data_word_out = '0;
          out_item_nxt.last_word     = 1'b1;
          out_item_nxt.is_empty      = ptr_eq;
          out_item_nxt.will_be_full  = (wnext_r == rp_r);
          out_item_nxt.has_room      = CMP_W'(room_words_r) >= CMP_W'(need_room_r);
          out_item_nxt.has_data      = !ptr_eq &&
                                       (CMP_W'(data_words_r) >= CMP_W'(need_data_r));
        end
      end
      ST_MOD_START: ;
      ST_MOD_WAIT: begin
        if (mod_done) begin
          case (mop_r)
            MOP_WP: begin
              wp_nxt  = ADDR_W'(mod_rem);
              mop_nxt = MOP_RP;
            end
            MOP_RP: begin
              rp_nxt  = ADDR_W'(mod_rem);
              mop_nxt = MOP_WADDR;
            end
            MOP_WADDR: begin
              waddr_nxt = ADDR_W'(mod_rem);
              mop_nxt   = MOP_WNEXT;
            end
            MOP_WNEXT: wnext_nxt = ADDR_W'(mod_rem);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mop_r       <= MOP_WP;
      norm_pend_r <= 1'b1;
      wp_abs_r    <= '0;
      wp_r        <= '0;
      rp_abs_r    <= '0;
      rp_r        <= '0;
      waddr_r     <= '0;
      wnext_r     <= '0;
      offset_r    <= '0;
      iss_cnt_r   <= '0;
      ld_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mop_r       <= mop_nxt;
      norm_pend_r <= norm_pend_nxt;
      wp_abs_r    <= wp_abs_nxt;
      wp_r        <= wp_nxt;
      rp_abs_r    <= rp_abs_nxt;
      rp_r        <= rp_nxt;
      waddr_r     <= waddr_nxt;
      wnext_r     <= wnext_nxt;
      offset_r    <= offset_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    raddr_r      <= raddr_nxt;
    req_r        <= req_nxt;
    room_words_r <= room_words_nxt;
    data_words_r <= data_words_nxt;
    need_room_r  <= need_room_nxt;
    need_data_r  <= need_data_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rrf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_insert),
    .waddr (waddr_r),
    .wdata (q_cmd.data_word),
    .re    (issue),
    .raddr (raddr_r),
    .rdata (ram_rdata)
  );

  rrf_mod #(
    .NUM_W (NUM_W),
    .DEN_W (SIZE_W)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (mod_num),
    .den   (bw),
    .done  (mod_done),
    .rem   (mod_rem)
  );

`ifndef NO_ASSERTIONS
  a_rd_pend_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_REM))
    else $error("read data pending outside a remove");

  a_ld_le_iss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REM) |-> (ld_cnt_r <= iss_cnt_r))
    else $error("more words delivered than read");

  a_mod_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_MOD_WAIT))
    else $error("remainder finished with nobody waiting");

  a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && !norm_pend_r) |->
      ((SIZE_W'(wp_r) < bw) && (SIZE_W'(rp_r) < bw) &&
       (SIZE_W'(waddr_r) < bw) && (SIZE_W'(wnext_r) < bw)))
    else $error("reduced pointer outside the ring");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/record_ring_fifo.sv -----
// Record ring FIFO top level: config registers, front end and back end.
//
// Usage:
//  in_*  : items (valid/stall). kind 0 writes one word into the open record,
//          kind 1 reads out one whole record, kind 2 asks about a record count.
//          kind 3 is taken and dropped.
//  out_* : results (valid/stall). A remove gives record_words words, the last
//          flagged; a query gives one flag item; an insert gives nothing.
//  cfg_* : write-only; index 0 record_words, index 1 buffer_words. Write only
//          while no item is in flight.
// Flow: inserts run one per cycle while the back end is idle and not
//  renormalizing. A remove reads its words through the single, registered RAM
//  read port into the output register, one word per cycle while the output is
//  not stalled. A query multiplies in ST_QRY1, compares in ST_QRY2 and then
//  registers its flags at the output. Closing a record when record_words
//  exceeds buffer_words goes through the bit-serial remainder unit (NUM_W = 12
//  by default). Reset and config writes trigger a renormalization of the
//  pointers: four remainder passes, during which items are queued but not executed.
// A stalled output holds its item; a two-entry command queue lets the input
//  keep flowing until it fills, then in_stall rises.
`default_nettype none

module record_ring_fifo import rrf_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int MAX_RECORD = DEF_MAX_RECORD
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W  = $clog2(RING_DEPTH);
  localparam int SIZE_W  = ADDR_W + 1;
  localparam int REC_W   = $clog2(MAX_RECORD + 1);
  localparam int RW_RST  = 1;
  localparam int BW_RST  = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;

  // Effective (clamped) sizes are stored, so nothing downstream clamps again.
  logic [REC_W-1:0]    rec_words_r, rec_words_nxt;
  logic [SIZE_W-1:0]   ring_words_r, ring_words_nxt;
  logic [CFG_RW_W-1:0] rw_field;
  logic [CFG_BW_W-1:0] bw_field;
  logic [REC_W-1:0]    rw_clamp;
  logic [SIZE_W-1:0]   bw_clamp;
  logic                q_valid, q_pop;
  cmd_t                q_cmd;

  assign rw_field = cfg_data[CFG_RW_W-1:0];
  assign bw_field = cfg_data[CFG_BW_W-1:0];

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (rw_field == '0) begin
      rw_clamp = REC_W'(1);
    end else if (32'(rw_field) > 32'(MAX_RECORD)) begin
      rw_clamp = REC_W'(MAX_RECORD);
    end else begin
      rw_clamp = REC_W'(rw_field);
    end
    if (bw_field == '0) begin
      bw_clamp = SIZE_W'(1);
    end else if (32'(bw_field) > 32'(RING_DEPTH)) begin
      bw_clamp = SIZE_W'(RING_DEPTH);
    end else begin
      bw_clamp = SIZE_W'(bw_field);
    end
  end

  always_comb begin
    rec_words_nxt  = rec_words_r;
    ring_words_nxt = ring_words_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RECORD_WORDS: rec_words_nxt  = rw_clamp;
        REG_BUFFER_WORDS: ring_words_nxt = bw_clamp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_words_r  <= REC_W'(RW_RST);
      ring_words_r <= SIZE_W'(BW_RST);
    end else begin
      rec_words_r  <= rec_words_nxt;
      ring_words_r <= ring_words_nxt;
    end
  end

  rrf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  rrf_back #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_RECORD (MAX_RECORD)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_written (cfg_we),
    .rw          (rec_words_r),
    .bw          (ring_words_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire
